// File: rtl/core/fema_pkg.sv
// Shared types and constants for the frame EMA smoother with spin-up.
// Used by fema_div, fema_dp, fema_ctrl and frame_ema_with_spin_up_core.
package fema_pkg;

	localparam int DEF_FRAME_SAMPLES = 65536;
	localparam int DEF_SAMPLE_BITS   = 8;
	localparam int DEF_FRAC_BITS     = 16;

	localparam int ALPHA_W    = 16;
	localparam int SPIN_W     = 16;
	localparam int FS_W       = 17;
	localparam int CNT_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SAMPLES = 2'd2;

	localparam logic [ALPHA_W-1:0] RST_ALPHA         = 16'd32768;
	localparam logic [SPIN_W-1:0]  RST_SPIN_UP       = 16'd1;
	localparam logic [FS_W-1:0]    RST_FRAME_SAMPLES = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DLOAD,
		ST_DIV,
		ST_MUL,
		ST_UPDATE,
		ST_EMIT
	} fema_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic dload;
		logic div_step;
		logic mul;
		logic update;
		logic emit;
	} fema_cmd_t;

	typedef struct packed {
		logic mode_copy;
		logic mode_div;
		logic out_free;
	} fema_status_t;

endpackage

// File: rtl/core/fema_div.sv
// Restoring divider, one quotient bit per step, used for the spin-up mean.
// Depends on fema_pkg for the divisor width.
module fema_div #(
	parameter int NUM_W = 25
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [NUM_W-1:0]          num,
	input  logic [fema_pkg::CNT_W-1:0] den,
	output logic [NUM_W-1:0]          quot
);
	import fema_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W:0]   trial;
	logic             qbit;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		qbit  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			num_q <= {num_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end

	assign quot = num_q;

endmodule

// File: rtl/core/fema_dp.sv
// Datapath: config registers, position and frame counters, accumulator store,
// difference, alpha multiply, update, rounding and output word register.
// Depends on fema_pkg and fema_div.
module fema_dp #(
	parameter int FRAME_SAMPLES = fema_pkg::DEF_FRAME_SAMPLES,
	parameter int SAMPLE_BITS   = fema_pkg::DEF_SAMPLE_BITS,
	parameter int FRAC_BITS     = fema_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fema_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fema_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [SAMPLE_BITS-1:0]         sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [SAMPLE_BITS-1:0]         smoothed,
	output logic                           frame_end,
	input  fema_pkg::fema_cmd_t            cmd,
	output fema_pkg::fema_status_t         status
);
	import fema_pkg::*;

	localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int STEP_W   = ACC_BITS + 1;
	localparam int PROD_W   = ACC_BITS + ALPHA_W;
	localparam int PW       = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int LIM_W    = ((PW > FS_W) ? PW : FS_W) + 1;

	logic [ALPHA_W-1:0] alpha_q;
	logic [SPIN_W-1:0]  spin_up_q;
	logic [FS_W-1:0]    frame_samples_q;

	logic [PW-1:0]          pos_q;
	logic [PW-1:0]          cur_pos_q;
	logic [CNT_W-1:0]       fc_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   last_q;
	logic [ACC_BITS-1:0]    rd_q;
	logic                   neg_q;
	logic [ACC_BITS-1:0]    mag_q;
	logic [PROD_W-1:0]      prod_q;
	logic [ACC_BITS-1:0]    acc_new_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   out_last_q;

	logic [ACC_BITS-1:0] mem [FRAME_SAMPLES];

	logic [SPIN_W-1:0]      su_eff;
	logic [LIM_W-1:0]       fs_ext;
	logic [LIM_W-1:0]       fs_eff;
	logic                   last;
	logic                   fc_inc;
	logic [ACC_BITS-1:0]    target;
	logic                   neg;
	logic [STEP_W-1:0]      div_num;
	logic [STEP_W-1:0]      quot;
	logic [PROD_W:0]        mul_sum;
	logic [STEP_W-1:0]      step;
	logic [STEP_W-1:0]      rd_ext;
	logic [STEP_W:0]        acc_sum;
	logic [ACC_BITS-1:0]    acc_next;
	logic [ACC_BITS:0]      rounded;
	logic [SAMPLE_BITS:0]   out_hi;
	logic [SAMPLE_BITS-1:0] out_sat;

	always_comb begin
		su_eff = (spin_up_q == '0) ? SPIN_W'(1) : spin_up_q;
		fs_ext = LIM_W'(frame_samples_q);
		if (frame_samples_q == '0)
			fs_eff = LIM_W'(1);
		else if (fs_ext > LIM_W'(FRAME_SAMPLES))
			fs_eff = LIM_W'(FRAME_SAMPLES);
		else
			fs_eff = fs_ext;
		last   = LIM_W'(pos_q) >= (fs_eff - LIM_W'(1));
		fc_inc = (pos_q == '0) && (fc_q <= {1'b0, su_eff});

		target  = {sample_q, {FRAC_BITS{1'b0}}};
		neg     = rd_q > target;
		div_num = STEP_W'(mag_q) + STEP_W'(fc_q[CNT_W-1:1]);

		// alpha step rounds half away from zero on the magnitude
		mul_sum = {1'b0, prod_q} + (PROD_W+1)'(1 << (ALPHA_W - 1));
		step    = status.mode_div ? quot : mul_sum[PROD_W:ALPHA_W];

		rd_ext  = STEP_W'(rd_q);
		acc_sum = {1'b0, rd_ext} + {1'b0, step};
		if (status.mode_copy)
			acc_next = target;
		else if (neg_q)
			acc_next = (step > rd_ext) ? '0 : ACC_BITS'(rd_ext - step);
		else if (acc_sum > (STEP_W+1)'({ACC_BITS{1'b1}}))
			acc_next = {ACC_BITS{1'b1}};
		else
			acc_next = acc_sum[ACC_BITS-1:0];

		rounded = {1'b0, acc_new_q} + ((ACC_BITS+1)'(1) << (FRAC_BITS - 1));
		out_hi  = rounded[ACC_BITS:FRAC_BITS];
		out_sat = out_hi[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : out_hi[SAMPLE_BITS-1:0];
	end

	always_comb begin
		status.mode_copy = fc_q <= CNT_W'(1);
		status.mode_div  = !status.mode_copy && (fc_q <= {1'b0, su_eff});
		status.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q         <= RST_ALPHA;
			spin_up_q       <= RST_SPIN_UP;
			frame_samples_q <= RST_FRAME_SAMPLES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:         alpha_q         <= cfg_data[ALPHA_W-1:0];
				REG_SPIN_UP:       spin_up_q       <= cfg_data[SPIN_W-1:0];
				REG_FRAME_SAMPLES: frame_samples_q <= cfg_data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pos_q <= last ? '0 : pos_q + PW'(1);
				if (fc_inc)
					fc_q <= fc_q + CNT_W'(1);
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_pos_q <= pos_q;
			last_q    <= last;
			sample_q  <= sample;
			rd_q      <= mem[pos_q];
		end
		if (cmd.update)
			mem[cur_pos_q] <= acc_next;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= neg;
			mag_q <= neg ? rd_q - target : target - rd_q;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(mag_q) * PROD_W'(alpha_q);
		if (cmd.update)
			acc_new_q <= acc_next;
		if (cmd.emit) begin
			out_data_q <= out_sat;
			out_last_q <= last_q;
		end
	end

	fema_div #(
		.NUM_W (STEP_W)
	) u_div (
		.clk  (clk),
		.load (cmd.dload),
		.step (cmd.div_step),
		.num  (div_num),
		.den  (fc_q),
		.quot (quot)
	);

	assign out_valid = out_valid_q;
	assign smoothed  = out_data_q;
	assign frame_end = out_last_q;

endmodule

// File: rtl/core/fema_ctrl.sv
// Controller: steps one word through read, copy/divide/multiply, update, emit.
// Depends on fema_pkg.
module fema_ctrl #(
	parameter int DIV_STEPS = fema_pkg::DEF_SAMPLE_BITS + fema_pkg::DEF_FRAC_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output fema_pkg::fema_cmd_t    cmd,
	input  fema_pkg::fema_status_t status
);
	import fema_pkg::*;

	localparam int DCW = $clog2(DIV_STEPS);

	fema_state_t    state_q;
	fema_state_t    state_nxt;
	logic [DCW-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.dload)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + DCW'(1);
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load = 1'b1;
				if (status.mode_copy)
					state_nxt = ST_UPDATE;
				else if (status.mode_div)
					state_nxt = ST_DLOAD;
				else
					state_nxt = ST_MUL;
			end
			ST_DLOAD: begin
				cmd.dload = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DCW'(DIV_STEPS - 1))
					state_nxt = ST_UPDATE;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/frame_ema_with_spin_up_core.sv
// Per-sample temporal EMA over a video stream with a running-mean spin-up.
//
// Input stream s_*: one sample word per beat, raster order, channels interleaved.
// Output stream m_*: one smoothed word per input word, in order; m_tlast marks
// the last sample of a frame. Config port: cfg_we with cfg_index 0 = alpha
// (Q0.16), 1 = spin_up (frames), 2 = frame_samples; write only while idle.
// Words are handled one at a time by a controller sequencing the datapath.
// Each word passes read, update and emit states, with a copy on the first frame;
// past spin-up a multiply state comes in between, and during spin-up a divider
// load and a bit-serial divide by the frame count (accumulator 8.16 by default).
// The result is registered: m_tvalid rises the cycle after the emit state, and
// the next word is taken while that result waits. If the receiver stalls, the
// following word finishes and then holds until the output register frees.
// Reset clears the counters and config to defaults; the accumulator store is
// not cleared, and entries within the first frame are copied before use.
// Depends on fema_pkg, fema_ctrl, fema_dp (with fema_div).
module frame_ema_with_spin_up_core #(
	parameter int FRAME_SAMPLES = fema_pkg::DEF_FRAME_SAMPLES,
	parameter int SAMPLE_BITS   = fema_pkg::DEF_SAMPLE_BITS,
	parameter int FRAC_BITS     = fema_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fema_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fema_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // smoothed
	output logic                              m_tlast
);
	import fema_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	fema_cmd_t              cmd;
	fema_status_t           status;
	logic [SAMPLE_BITS-1:0] smoothed;

	fema_ctrl #(
		.DIV_STEPS (SAMPLE_BITS + FRAC_BITS + 1)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	fema_dp #(
		.FRAME_SAMPLES (FRAME_SAMPLES),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.smoothed  (smoothed),
		.frame_end (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

	assign m_tdata = DATA_W'(smoothed);

endmodule

// File: test/tb_frame_ema_with_spin_up_core.sv
// Self-checking bench for frame_ema_with_spin_up_core: stream driver, monitor and a
// bit-accurate predictor of the per-position smoothing, with config phases in between.
// Depends on fema_pkg and the core RTL.
module tb_frame_ema_with_spin_up_core;
	import fema_pkg::*;

	localparam int FRAME_SAMPLES = DEF_FRAME_SAMPLES;
	localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
	localparam int FRAC_BITS     = DEF_FRAC_BITS;
	localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam logic [63:0] ACC_MAX = (64'd1 << (SAMPLE_BITS + FRAC_BITS)) - 64'd1;
	localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;
	// size of the first frame; only these positions ever get written
	localparam int FIRST_FS    = 16;
	localparam int TAIL_CYCLES = SAMPLE_BITS + FRAC_BITS + 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEM_TARGET = 900;
	// ring buffers for pending words and expected results
	localparam int QAW    = 8;
	localparam int QDEPTH = 1 << QAW;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smoothed;
		logic                   frame_end;
	} ema_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata = '0;    // sample
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;         // smoothed
	logic                  m_tlast;

	frame_ema_with_spin_up_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [SAMPLE_BITS+FRAC_BITS-1:0] acc_mem [0:FRAME_SAMPLES-1];
	int unsigned     pos_m = 0;
	int unsigned     frames_m = 0;
	logic [ALPHA_W-1:0] alpha_m = RST_ALPHA;
	logic [SPIN_W-1:0]  spin_m = RST_SPIN_UP;
	logic [FS_W-1:0]    fs_m = RST_FRAME_SAMPLES;

	logic [SAMPLE_BITS-1:0] sample_buf [QDEPTH];
	ema_result_t            result_buf [QDEPTH];
	logic [QAW-1:0]         sample_wr = '0;
	logic [QAW-1:0]         sample_rd = '0;
	logic [QAW-1:0]         result_wr = '0;
	logic [QAW-1:0]         result_rd = '0;
	ema_result_t            want;

	int  cycle_cnt = 0;
	int  mismatches = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  src_pct = 0;
	int  snk_pct = 0;
	logic src_took = 1'b0;
	logic next_valid;

	// Predict one sample and queue it. Refuses (ok = 0) a sample that would leave the
	// next position on a store entry that was never written.
	task automatic smooth_sample(input logic [SAMPLE_BITS-1:0] s, output bit ok);
		logic [63:0] target, acc, mag, step, o;
		int unsigned fs, su, p, nxt;
		logic neg, last;
		ema_result_t r;
		if (fs_m == 0) fs = 1;
		else if (fs_m > FRAME_SAMPLES) fs = FRAME_SAMPLES;
		else fs = fs_m;
		su = (spin_m == 0) ? 1 : spin_m;
		p = (pos_m >= FRAME_SAMPLES) ? FRAME_SAMPLES - 1 : pos_m;
		last = (p >= fs - 1);
		nxt = last ? 0 : p + 1;
		ok = (nxt < FIRST_FS);
		if (ok) begin
			target = 64'(s) << FRAC_BITS;
			if (p == 0 && frames_m <= su) frames_m++;
			acc = 64'(acc_mem[p]);
			if (frames_m <= 1) begin
				acc = target;
			end else begin
				neg = acc > target;
				mag = neg ? acc - target : target - acc;
				if (frames_m <= su) step = (mag + 64'(frames_m / 2)) / 64'(frames_m);
				else step = (mag * 64'(alpha_m) + 64'd32768) >> 16;
				if (neg) acc = (step > acc) ? 64'd0 : acc - step;
				else acc = acc + step;
				if (acc > ACC_MAX) acc = ACC_MAX;
			end
			acc_mem[p] = acc[SAMPLE_BITS+FRAC_BITS-1:0];
			o = (acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (o > SAMPLE_MAX) o = SAMPLE_MAX;
			pos_m = nxt;
			r.smoothed = o[SAMPLE_BITS-1:0];
			r.frame_end = last;
			result_buf[result_wr] = r;
			result_wr = result_wr + QAW'(1);
			sample_buf[sample_wr] = s;
			sample_wr = sample_wr + QAW'(1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ALPHA:         alpha_m = val[ALPHA_W-1:0];
			REG_SPIN_UP:       spin_m = val[SPIN_W-1:0];
			REG_FRAME_SAMPLES: fs_m = val[FS_W-1:0];
			default: ;
		endcase
	endtask

	// sender holds off until every queued word is through and every result is back
	task automatic settle();
		while (sample_wr != sample_rd || s_tvalid || result_wr != result_rd)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// source side
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !src_took)) begin
			next_valid = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (sample_wr != sample_rd) begin
				if (src_pct != 0 && $urandom_range(99) < src_pct) begin
					src_gap = $urandom_range(0, 10);
				end else begin
					next_valid = 1'b1;
					s_tdata <= TDATA_W'(sample_buf[sample_rd]);
					sample_rd = sample_rd + QAW'(1);
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// sink side
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (snk_pct != 0 && $urandom_range(99) < snk_pct) begin
				snk_gap = $urandom_range(0, 10);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		src_took <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_wr == result_rd) begin
				if (mismatches < 10)
					$display("unexpected word: smoothed %0d frame_end %0d", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = result_buf[result_rd];
				result_rd = result_rd + QAW'(1);
				if (m_tdata !== TDATA_W'(want.smoothed) || m_tlast !== want.frame_end) begin
					if (mismatches < 10)
						$display("mismatch @%0d: smoothed exp %0d got %0d, frame_end exp %0d got %0d",
							cycle_cnt, want.smoothed, m_tdata, want.frame_end, m_tlast);
					mismatches++;
				end
			end
		end
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("frame_ema_with_spin_up_core verification failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] val;
		logic [SAMPLE_BITS-1:0] base, s;
		logic [SAMPLE_BITS-1:0] opening [0:FIRST_FS-1];
		int n, total;
		bit ok;
		opening = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F, 8'h80,
			8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h00, 8'h00, 8'hFF, 8'hFF};
		total = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first frame: copies every position once
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(FIRST_FS));
		write_reg(REG_SPIN_UP, CFG_DATA_W'(3));
		src_pct = 20;
		snk_pct = 20;
		for (int i = 0; i < FIRST_FS; i++) begin
			smooth_sample(opening[i], ok);
			total++;
		end
		settle();

		// zero spin-up acts as one: straight into the alpha step
		write_reg(REG_SPIN_UP, '0);
		smooth_sample(8'hFF, ok);
		smooth_sample(8'h00, ok);
		settle();
		// zero alpha holds the values
		write_reg(REG_ALPHA, '0);
		smooth_sample(8'h00, ok);
		smooth_sample(8'hFF, ok);
		settle();
		// frame size 0 acts as 1, then sizes above the store clamp
		write_reg(REG_FRAME_SAMPLES, '0);
		smooth_sample(8'h80, ok);
		smooth_sample(8'h81, ok);
		settle();
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(131071));
		smooth_sample(8'h10, ok);
		smooth_sample(8'hEF, ok);
		settle();
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(65536));
		smooth_sample(8'h33, ok);
		smooth_sample(8'hCC, ok);
		settle();
		// shrink mid-frame: ends at the next word
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(2));
		smooth_sample(8'h44, ok);
		total += 13;

		while (total < ITEM_TARGET - 60) begin
			settle();
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(5))
					0: val = '0;
					1: val = CFG_DATA_W'(1);
					2: val = CFG_DATA_W'(16'hFFFF);
					default: val = CFG_DATA_W'($urandom_range(1, 65535));
				endcase
				write_reg(REG_ALPHA, val);
			end
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(7))
					0: val = '0;
					1: val = CFG_DATA_W'(1);
					2: val = CFG_DATA_W'(16'hFFFF);
					default: val = CFG_DATA_W'($urandom_range(2, 8));
				endcase
				write_reg(REG_SPIN_UP, val);
			end
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(9))
					0: val = '0;
					1: val = CFG_DATA_W'(1);
					2: val = CFG_DATA_W'(FIRST_FS);
					3: val = CFG_DATA_W'($urandom_range(FIRST_FS + 1, 131071));
					4: val = CFG_DATA_W'(131071);
					default: val = CFG_DATA_W'($urandom_range(1, FIRST_FS));
				endcase
				write_reg(REG_FRAME_SAMPLES, val);
			end
			src_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
			snk_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
			base = SAMPLE_BITS'($urandom_range(0, 255));
			n = $urandom_range(8, 60);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(9))
					0, 1, 2, 3: s = SAMPLE_BITS'($urandom_range(0, 255));
					4:          s = $urandom_range(1) ? 8'hFF : 8'h00;
					default:    s = base + 8'($urandom_range(0, 6)) - 8'd3;
				endcase
				smooth_sample(s, ok);
				if (!ok) break;
				total++;
			end
		end

		// closing stretch at full rate
		settle();
		src_pct = 0;
		snk_pct = 0;
		write_reg(REG_FRAME_SAMPLES, CFG_DATA_W'(FIRST_FS));
		write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(1, 65535)));
		write_reg(REG_SPIN_UP, CFG_DATA_W'($urandom_range(1, 4)));
		for (int i = 0; i < 60; i++) begin
			smooth_sample(8'($urandom_range(0, 255)), ok);
		end
		settle();

		if (mismatches == 0 && result_wr == result_rd) begin
			$display("frame_ema_with_spin_up_core verification clean");
		end else begin
			$display("frame_ema_with_spin_up_core verification failed");
		end
		$finish;
	end
endmodule
